[hw/rtl/scfla_pkg.sv]
package scfla_pkg;

  localparam int ADDR_W   = 18;
  localparam int CLASS_W  = 4;
  localparam int SIZE_W   = 32;
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 3;

  localparam int SMALLEST_CLASS_DEF = 3;
  localparam int LARGEST_CLASS_DEF  = 12;
  localparam int SLAB_BYTES_DEF     = 4096;
  localparam int NUM_SLABS_DEF      = 64;
  localparam int STACK_DEPTH_DEF    = 512;

  localparam logic [CMD_W-1:0] CMD_ALLOC  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FREE   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_CLASS = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NO_SLAB   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 3'd4;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [CLASS_W-1:0] blk_class;
    logic [ADDR_W-1:0]  block_address;
    logic [SIZE_W-1:0]  req_bytes;
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   address_out;
    logic [CLASS_W-1:0]  class_out;
    logic [STATUS_W-1:0] status;
  } rsp_t;

endpackage

[hw/rtl/scfla_stack_mem.sv]
module scfla_stack_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/scfla_class_meta.sv]
module scfla_class_meta #(
  parameter int NROWS = 10,
  parameter int RW    = 4,
  parameter int TW    = 10,
  parameter int SW    = 7
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [RW-1:0] row_i,
  output logic [TW-1:0] top_o,
  output logic [TW-1:0] lazy_o,
  output logic [SW-1:0] base_o,
  output logic [SW-1:0] next_slab_o,
  input  logic          we_i,
  input  logic [TW-1:0] top_i,
  input  logic [TW-1:0] lazy_i,
  input  logic [SW-1:0] base_i,
  input  logic          slab_inc_i
);

  // lazy: entries below this index still hold their carved address
  logic [TW-1:0] top_q  [NROWS];
  logic [TW-1:0] lazy_q [NROWS];
  logic [SW-1:0] base_q [NROWS];
  logic [SW-1:0] next_slab_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NROWS; i++) begin
        top_q[i]  <= '0;
        lazy_q[i] <= '0;
        base_q[i] <= '0;
      end
      next_slab_q <= '0;
    end else begin
      if (we_i) begin
        top_q[row_i]  <= top_i;
        lazy_q[row_i] <= lazy_i;
        base_q[row_i] <= base_i;
      end
      if (slab_inc_i) begin
        next_slab_q <= next_slab_q + SW'(1);
      end
    end
  end

  assign top_o       = top_q[row_i];
  assign lazy_o      = lazy_q[row_i];
  assign base_o      = base_q[row_i];
  assign next_slab_o = next_slab_q;

endmodule

[hw/rtl/scfla_size_class.sv]
module scfla_size_class #(
  parameter int SMALLEST_CLASS = scfla_pkg::SMALLEST_CLASS_DEF,
  parameter int LARGEST_CLASS  = scfla_pkg::LARGEST_CLASS_DEF
) (
  input  logic [scfla_pkg::SIZE_W-1:0]  size_i,
  output logic [scfla_pkg::CLASS_W-1:0] class_o,
  output logic                          too_large_o
);

  logic [scfla_pkg::SIZE_W-1:0]  v;
  logic [scfla_pkg::CLASS_W-1:0] k;
  logic                          zero;

  always_comb begin
    zero = (size_i == '0);
    v    = size_i - scfla_pkg::SIZE_W'(1);
    k    = '0;
    for (int i = 0; i < LARGEST_CLASS; i++) begin
      if (v[i]) begin
        k = scfla_pkg::CLASS_W'(i + 1);
      end
    end
    if (k < scfla_pkg::CLASS_W'(SMALLEST_CLASS)) begin
      k = scfla_pkg::CLASS_W'(SMALLEST_CLASS);
    end
    too_large_o = !zero && ((v >> LARGEST_CLASS) != '0);
    class_o     = (zero || too_large_o) ? '0 : k;
  end

endmodule

[hw/rtl/slab_class_free_list_allocator.sv]
// channel   | signals                  | handshake
// ----------+--------------------------+-------------------------------------
// request   | start_i, busy_o, req_i   | taken when start_i high and busy_o low
// result    | done_o, rsp_o            | one-cycle strobe, always taken
//
// a transaction is accepted in S_IDLE and then executed in S_EXEC
// a pop served from the stack memory adds the S_READ state for its registered read port
// carved addresses are computed lazily from per-class slab and lazy counts
// reset clears all class counters and the slab counter; no clearing pass
// busy_o is low in the cycle the result is shown, so a new request may enter then
module slab_class_free_list_allocator #(
  parameter int SMALLEST_CLASS = scfla_pkg::SMALLEST_CLASS_DEF,
  parameter int LARGEST_CLASS  = scfla_pkg::LARGEST_CLASS_DEF,
  parameter int SLAB_BYTES     = scfla_pkg::SLAB_BYTES_DEF,
  parameter int NUM_SLABS      = scfla_pkg::NUM_SLABS_DEF,
  parameter int STACK_DEPTH    = scfla_pkg::STACK_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  scfla_pkg::req_t   req_i,
  output logic              done_o,
  output scfla_pkg::rsp_t   rsp_o
);

  localparam int NROWS  = LARGEST_CLASS - SMALLEST_CLASS + 1;
  localparam int RW     = (NROWS > 1) ? $clog2(NROWS) : 1;
  localparam int TW     = $clog2(STACK_DEPTH + 1);
  localparam int SW     = $clog2(NUM_SLABS + 1);
  localparam int MDEPTH = NROWS * STACK_DEPTH;
  localparam int MAW    = $clog2(MDEPTH);
  localparam int PW     = $clog2(SLAB_BYTES + 1);
  localparam int AW     = scfla_pkg::ADDR_W;
  localparam int CW     = scfla_pkg::CLASS_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ
  } state_e;

  state_e          state_q;
  logic            done_q;
  scfla_pkg::rsp_t rsp_q, rsp_d;
  scfla_pkg::req_t req_q;

  logic [CW-1:0]  cls;
  logic           cls_ok;
  logic [RW-1:0]  row;
  logic [TW-1:0]  meta_top, meta_lazy, top_m1, top_n, lazy_n, carve_cnt, idx_sel;
  logic [SW-1:0]  meta_base, next_slab, base_n, slab_sel;
  logic           meta_we, slab_inc, exec, go_read;
  logic [PW-1:0]  perslab;
  logic [AW-1:0]  calc_addr;
  logic           mem_we, mem_re;
  logic [MAW-1:0] row_off, mem_addr;
  logic [AW-1:0]  mem_rdata;
  logic [CW-1:0]  q_class;
  logic           q_too_large;

  scfla_class_meta #(
    .NROWS (NROWS),
    .RW    (RW),
    .TW    (TW),
    .SW    (SW)
  ) u_meta (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .row_i       (row),
    .top_o       (meta_top),
    .lazy_o      (meta_lazy),
    .base_o      (meta_base),
    .next_slab_o (next_slab),
    .we_i        (meta_we),
    .top_i       (top_n),
    .lazy_i      (lazy_n),
    .base_i      (base_n),
    .slab_inc_i  (slab_inc)
  );

  scfla_stack_mem #(
    .DEPTH (MDEPTH),
    .WIDTH (AW)
  ) u_stack_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_addr),
    .wdata_i (req_q.block_address),
    .re_i    (mem_re),
    .raddr_i (mem_addr),
    .rdata_o (mem_rdata)
  );

  scfla_size_class #(
    .SMALLEST_CLASS (SMALLEST_CLASS),
    .LARGEST_CLASS  (LARGEST_CLASS)
  ) u_size_class (
    .size_i      (req_q.req_bytes),
    .class_o     (q_class),
    .too_large_o (q_too_large)
  );

  always_comb begin
    exec      = (state_q == S_EXEC);
    cls       = req_q.blk_class;
    cls_ok    = (cls >= CW'(SMALLEST_CLASS)) && (cls <= CW'(LARGEST_CLASS));
    row       = RW'(cls - CW'(SMALLEST_CLASS));
    top_m1    = meta_top - TW'(1);
    perslab   = PW'(SLAB_BYTES) >> cls;
    if (32'(perslab) < 32'(STACK_DEPTH)) begin
      carve_cnt = TW'(perslab);
    end else begin
      carve_cnt = TW'(STACK_DEPTH);
    end
    idx_sel   = (meta_top == '0) ? (carve_cnt - TW'(1)) : top_m1;
    slab_sel  = (meta_top == '0) ? next_slab : meta_base;
    calc_addr = AW'(AW'(slab_sel) * AW'(SLAB_BYTES)) + (AW'(idx_sel) << cls);
    row_off   = MAW'(MAW'(row) * MAW'(STACK_DEPTH));

    meta_we  = 1'b0;
    slab_inc = 1'b0;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    go_read  = 1'b0;
    top_n    = meta_top;
    lazy_n   = meta_lazy;
    base_n   = meta_base;
    mem_addr = row_off + MAW'(top_m1);
    rsp_d    = '0;
    rsp_d.status = scfla_pkg::ST_OK;

    case (req_q.cmd)
      scfla_pkg::CMD_ALLOC: begin
        if (!cls_ok) begin
          rsp_d.status = scfla_pkg::ST_BAD_CLASS;
        end else if (meta_top == '0) begin
          if ((next_slab >= SW'(NUM_SLABS)) || (perslab == '0)) begin
            rsp_d.status = scfla_pkg::ST_NO_SLAB;
          end else begin
            meta_we  = 1'b1;
            slab_inc = 1'b1;
            top_n    = carve_cnt - TW'(1);
            lazy_n   = carve_cnt - TW'(1);
            base_n   = next_slab;
            rsp_d.address_out = calc_addr;
          end
        end else begin
          meta_we = 1'b1;
          top_n   = top_m1;
          if (top_m1 < meta_lazy) begin
            lazy_n = top_m1;
            rsp_d.address_out = calc_addr;
          end else begin
            mem_re  = 1'b1;
            go_read = 1'b1;
          end
        end
      end
      scfla_pkg::CMD_FREE: begin
        if (!cls_ok) begin
          rsp_d.status = scfla_pkg::ST_BAD_CLASS;
        end else if (meta_top >= TW'(STACK_DEPTH)) begin
          rsp_d.status = scfla_pkg::ST_FULL;
        end else begin
          mem_we   = 1'b1;
          mem_addr = row_off + MAW'(meta_top);
          meta_we  = 1'b1;
          top_n    = meta_top + TW'(1);
        end
      end
      scfla_pkg::CMD_QUERY: begin
        rsp_d.class_out = q_class;
        rsp_d.status    = q_too_large ? scfla_pkg::ST_TOO_LARGE : scfla_pkg::ST_OK;
      end
      default: begin
        rsp_d = '0;
      end
    endcase

    meta_we  = meta_we && exec;
    slab_inc = slab_inc && exec;
    mem_we   = mem_we && exec;
    mem_re   = mem_re && exec;
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      req_q <= req_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
      rsp_q   <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          done_q <= 1'b0;
          if (start_i) begin
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (go_read) begin
            state_q <= S_READ;
            done_q  <= 1'b0;
          end else begin
            state_q <= S_IDLE;
            done_q  <= 1'b1;
            rsp_q   <= rsp_d;
          end
        end
        S_READ: begin
          state_q           <= S_IDLE;
          done_q            <= 1'b1;
          rsp_q.address_out <= mem_rdata;
          rsp_q.class_out   <= '0;
          rsp_q.status      <= scfla_pkg::ST_OK;
        end
        default: begin
          state_q <= S_IDLE;
          done_q  <= 1'b0;
        end
      endcase
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

`ifndef NO_ASSERTIONS
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o && !done_o)
    else $error("accepted transaction did not enter execute");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for more than one cycle");

  a_read_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_re |=> state_q == S_READ)
    else $error("stack read not followed by read-data cycle");

  a_mem_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_re && mem_we))
    else $error("stack memory read and write in the same cycle");

  a_meta_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec && cls_ok |-> meta_lazy <= meta_top && meta_top <= TW'(STACK_DEPTH))
    else $error("class counters out of order");
`endif

endmodule

[test/testbench.sv]
`timescale 1ns / 100ps

module testbench;

  typedef struct {
    logic [scfla_pkg::CLASS_W-1:0] cls;
    logic [scfla_pkg::ADDR_W-1:0]  addr;
  } held_block_t;

  class alloc_scoreboard;
    logic [scfla_pkg::ADDR_W-1:0] block_store [16][scfla_pkg::STACK_DEPTH_DEF];
    int unsigned fill_count [16];
    int unsigned slabs_used;
    scfla_pkg::rsp_t pending_rsp [$];
    held_block_t held_blocks [$];
    int errors;

    function new();
      foreach (fill_count[c]) fill_count[c] = 0;
      slabs_used = 0;
      errors = 0;
    endfunction

    function scfla_pkg::rsp_t serve(scfla_pkg::req_t r);
      scfla_pkg::rsp_t rsp;
      int unsigned c;
      int unsigned per_slab;
      int unsigned n;
      int unsigned k;
      logic [scfla_pkg::SIZE_W-1:0] v;
      held_block_t hb;
      rsp = '0;
      c = r.blk_class;
      case (r.cmd)
        scfla_pkg::CMD_ALLOC: begin
          if (c < scfla_pkg::SMALLEST_CLASS_DEF || c > scfla_pkg::LARGEST_CLASS_DEF) begin
            rsp.status = scfla_pkg::ST_BAD_CLASS;
          end else begin
            if (fill_count[c] == 0) begin
              per_slab = scfla_pkg::SLAB_BYTES_DEF >> c;
              if (slabs_used >= scfla_pkg::NUM_SLABS_DEF || per_slab == 0) begin
                rsp.status = scfla_pkg::ST_NO_SLAB;
              end else begin
                n = (per_slab < scfla_pkg::STACK_DEPTH_DEF) ? per_slab
                                                             : scfla_pkg::STACK_DEPTH_DEF;
                for (int i = 0; i < n; i++) begin
                  block_store[c][i] = scfla_pkg::ADDR_W'(
                      slabs_used * scfla_pkg::SLAB_BYTES_DEF + (i << c));
                end
                fill_count[c] = n;
                slabs_used++;
              end
            end
            if (rsp.status == scfla_pkg::ST_OK) begin
              fill_count[c]--;
              rsp.address_out = block_store[c][fill_count[c]];
              hb.cls = r.blk_class;
              hb.addr = rsp.address_out;
              held_blocks.push_back(hb);
            end
          end
        end
        scfla_pkg::CMD_FREE: begin
          if (c < scfla_pkg::SMALLEST_CLASS_DEF || c > scfla_pkg::LARGEST_CLASS_DEF) begin
            rsp.status = scfla_pkg::ST_BAD_CLASS;
          end else if (fill_count[c] >= scfla_pkg::STACK_DEPTH_DEF) begin
            rsp.status = scfla_pkg::ST_FULL;
          end else begin
            block_store[c][fill_count[c]] = r.block_address;
            fill_count[c]++;
          end
        end
        scfla_pkg::CMD_QUERY: begin
          if (r.req_bytes != '0) begin
            v = r.req_bytes - 1'b1;
            k = 0;
            while (v != '0) begin
              v = v >> 1;
              k++;
            end
            if (k < scfla_pkg::SMALLEST_CLASS_DEF) k = scfla_pkg::SMALLEST_CLASS_DEF;
            if (k > scfla_pkg::LARGEST_CLASS_DEF) rsp.status = scfla_pkg::ST_TOO_LARGE;
            else rsp.class_out = scfla_pkg::CLASS_W'(k);
          end
        end
        default: begin
        end
      endcase
      return rsp;
    endfunction

    function void note_request(scfla_pkg::req_t r);
      pending_rsp.push_back(serve(r));
    endfunction

    function void check_result(scfla_pkg::rsp_t got);
      scfla_pkg::rsp_t exp;
      if (pending_rsp.size() == 0) begin
        $error("unexpected result: address_out %0h class_out %0d status %0d",
               got.address_out, got.class_out, got.status);
        errors++;
        return;
      end
      exp = pending_rsp.pop_front();
      if (got.address_out !== exp.address_out) begin
        $error("address_out: expected %0h, got %0h", exp.address_out, got.address_out);
        errors++;
      end
      if (got.class_out !== exp.class_out) begin
        $error("class_out: expected %0d, got %0d", exp.class_out, got.class_out);
        errors++;
      end
      if (got.status !== exp.status) begin
        $error("status: expected %0d, got %0d", exp.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  scfla_pkg::req_t req_i = '0;
  logic done_o;
  scfla_pkg::rsp_t rsp_o;

  alloc_scoreboard alloc_sb;
  int idle_pct;

  slab_class_free_list_allocator dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .req_i   (req_i),
    .done_o  (done_o),
    .rsp_o   (rsp_o)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) alloc_sb.check_result(rsp_o);
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic scfla_pkg::req_t make_req(logic [scfla_pkg::CMD_W-1:0] cmd,
                                               int unsigned cls, int unsigned addr,
                                               logic [scfla_pkg::SIZE_W-1:0] size);
    scfla_pkg::req_t r;
    r.cmd = cmd;
    r.blk_class = scfla_pkg::CLASS_W'(cls);
    r.block_address = scfla_pkg::ADDR_W'(addr);
    r.req_bytes = size;
    return r;
  endfunction

  function automatic scfla_pkg::req_t random_req();
    scfla_pkg::req_t r;
    int unsigned pick;
    int unsigned idx;
    held_block_t hb;
    r.cmd = scfla_pkg::CMD_ALLOC;
    r.blk_class = scfla_pkg::CLASS_W'($urandom_range(0, 15));
    r.block_address = scfla_pkg::ADDR_W'($urandom_range(0, 262143));
    r.req_bytes = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      r.cmd = scfla_pkg::CMD_ALLOC;
      if ($urandom_range(0, 99) < 85)
        r.blk_class = scfla_pkg::CLASS_W'($urandom_range(scfla_pkg::SMALLEST_CLASS_DEF,
                                                         scfla_pkg::LARGEST_CLASS_DEF));
    end else if (pick < 75) begin
      r.cmd = scfla_pkg::CMD_FREE;
      if (alloc_sb.held_blocks.size() != 0 && $urandom_range(0, 99) < 85) begin
        idx = $urandom_range(0, alloc_sb.held_blocks.size() - 1);
        hb = alloc_sb.held_blocks[idx];
        alloc_sb.held_blocks.delete(idx);
        r.blk_class = hb.cls;
        r.block_address = hb.addr;
      end
    end else if (pick < 95) begin
      r.cmd = scfla_pkg::CMD_QUERY;
      case ($urandom_range(0, 3))
        0: r.req_bytes = $urandom;
        1: r.req_bytes = $urandom_range(0, 4200);
        2: r.req_bytes = (32'd1 << $urandom_range(0, 31)) + 32'($urandom_range(0, 2)) - 32'd1;
        default: r.req_bytes = $urandom_range(0, 16);
      endcase
    end else begin
      r.cmd = scfla_pkg::CMD_UNUSED;
    end
    return r;
  endfunction

  task automatic pause_sender();
    if ($urandom_range(0, 99) < idle_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
  endtask

  // one transaction: hold the request until it is taken
  task automatic issue(input scfla_pkg::req_t r);
    start_i <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    alloc_sb.note_request(r);
    pause_sender();
  endtask

  task automatic drain_results();
    start_i <= 1'b0;
    do @(posedge clk_i); while (alloc_sb.pending_rsp.size() != 0);
  endtask

  task automatic run_random(input int count, input bit allow_idle);
    int sel;
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0) begin
        sel = $urandom_range(0, 2);
        idle_pct = !allow_idle ? 0 : (sel == 0) ? 0 : (sel == 1) ? 10 : 35;
      end
      issue(random_req());
    end
  endtask

  initial begin
    alloc_sb = new();
    idle_pct = 20;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    issue(make_req(scfla_pkg::CMD_QUERY, 0, 0, 32'd0));
    issue(make_req(scfla_pkg::CMD_QUERY, 15, 262143, 32'd1));
    issue(make_req(scfla_pkg::CMD_QUERY, 0, 0, 32'd8));
    issue(make_req(scfla_pkg::CMD_QUERY, 0, 0, 32'd9));
    issue(make_req(scfla_pkg::CMD_QUERY, 0, 0, 32'd4096));
    issue(make_req(scfla_pkg::CMD_QUERY, 0, 0, 32'd4097));
    issue(make_req(scfla_pkg::CMD_QUERY, 0, 0, 32'hFFFF_FFFF));
    issue(make_req(scfla_pkg::CMD_ALLOC, 2, 0, 32'd0));
    issue(make_req(scfla_pkg::CMD_ALLOC, 13, 0, 32'd0));
    issue(make_req(scfla_pkg::CMD_ALLOC, 15, 262143, 32'hFFFF_FFFF));
    issue(make_req(scfla_pkg::CMD_FREE, 0, 4, 32'd0));
    issue(make_req(scfla_pkg::CMD_ALLOC, 3, 0, 32'd0));
    issue(make_req(scfla_pkg::CMD_FREE, 3, 262143, 32'd0));
    issue(make_req(scfla_pkg::CMD_FREE, 3, 8, 32'd0));
    issue(make_req(scfla_pkg::CMD_ALLOC, 3, 0, 32'd0));
    issue(make_req(scfla_pkg::CMD_ALLOC, 12, 0, 32'd0));
    issue(make_req(scfla_pkg::CMD_FREE, 12, 0, 32'd0));
    issue(make_req(scfla_pkg::CMD_ALLOC, 12, 0, 32'd0));
    issue(make_req(scfla_pkg::CMD_ALLOC, 4, 0, 32'd0));
    issue(make_req(scfla_pkg::CMD_FREE, 11, 1024, 32'd0));
    issue(make_req(scfla_pkg::CMD_UNUSED, 15, 262143, 32'hFFFF_FFFF));
    issue(make_req(scfla_pkg::CMD_ALLOC, 11, 0, 32'd0));

    run_random(700, 1'b1);
    drain_results();

    // use up the remaining slabs, then empty the largest class
    while (alloc_sb.slabs_used < scfla_pkg::NUM_SLABS_DEF)
      issue(make_req(scfla_pkg::CMD_ALLOC, $urandom_range(11, 12),
                     $urandom_range(0, 262143), $urandom));
    while (alloc_sb.fill_count[scfla_pkg::LARGEST_CLASS_DEF] != 0)
      issue(make_req(scfla_pkg::CMD_ALLOC, scfla_pkg::LARGEST_CLASS_DEF, 0, 32'd0));
    repeat (3) issue(make_req(scfla_pkg::CMD_ALLOC, scfla_pkg::LARGEST_CLASS_DEF, 0, 32'd0));

    run_random(520, 1'b1);
    run_random(200, 1'b0);
    drain_results();
    repeat (12) @(posedge clk_i);

    if (alloc_sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
